[sv/skt_pkg.sv]
// ----------------------------------------------------------------------------
// skt_pkg
// Shared constants for the streaming top-k nearest neighbor selector.
// ----------------------------------------------------------------------------
package skt_pkg;

  localparam int VAL_W  = 8;
  localparam int SQ_W   = 2 * VAL_W;
  localparam int DIST_W = 32;
  localparam int TOPK_W = 6;

  localparam logic [TOPK_W-1:0] TOPK_RESET = 6'd20;
  localparam logic [DIST_W-1:0] SUM_MAX    = 32'hFFFF_FFFF;

  // Register word index on the configuration port
  localparam logic [1:0] REG_TOP_K = 2'd0;

  localparam logic MODE_PAIR  = 1'b0;
  localparam logic MODE_DRAIN = 1'b1;

endpackage

[sv/skt_ram.sv]
// ----------------------------------------------------------------------------
// skt_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module skt_ram #(
  parameter int WIDTH = 56,
  parameter int DEPTH = 32
) (
  input  logic                                     clk,
  input  logic                                     we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                         wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[sv/streaming_knn_top_k_unit.sv]
// Operation: a component transaction holds busy from start until its square is accumulated;
//   a last component also offers its pair, which is appended while the set fills, or else is
//   decided on, and then a max scan runs through the entry RAM. A drain clears the set, then
//   finds every result by a full pass over the n kept entries with the one shared comparator.
// Reset: rst (synchronous, active high) clears the sum, index, set count and top_k (to 20);
//   entry storage is not cleared. Results are one-cycle strobes; the receiver cannot stall.
// ----------------------------------------------------------------------------
// streaming_knn_top_k_unit
// Squared Euclidean distance accumulator with a top-k (distance, index) set,
// drained in ascending order by repeated minimum scans.
// ----------------------------------------------------------------------------
module streaming_knn_top_k_unit #(
  parameter int K_MAX      = 32,
  parameter int INDEX_BITS = 24
) (
  input  logic                        clk,
  input  logic                        rst,
  // command channel
  input  logic                        start,
  output logic                        busy,
  input  logic                        mode,
  input  logic [skt_pkg::VAL_W-1:0]   query_value,
  input  logic [skt_pkg::VAL_W-1:0]   base_value,
  input  logic                        last_component,
  // result channel
  output logic                        result_valid,
  output logic [INDEX_BITS-1:0]       neighbor_index,
  output logic [skt_pkg::DIST_W-1:0]  distance,
  output logic                        empty_res,
  output logic                        last_result,
  // configuration port
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [1:0]                  paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready
);

  localparam int AW = (K_MAX > 1) ? $clog2(K_MAX) : 1;   // entry address
  localparam int CW = $clog2(K_MAX + 1);                 // entry count
  localparam int DW = skt_pkg::DIST_W;
  localparam int EW = DW + INDEX_BITS;                   // RAM word: {distance, index}

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ACC,    // add the registered square into the running sum
    ST_OFFER,  // insert, or start the max scan
    ST_MSCAN,  // find the largest kept pair, replace if the offer is smaller
    ST_DRAIN,  // snapshot and clear the set
    ST_DSCAN   // find the smallest unsent pair and emit it
  } state_t;

  state_t                      state;
  logic [skt_pkg::TOPK_W-1:0]  top_k;
  logic [DW-1:0]               running_sum;
  logic [INDEX_BITS-1:0]       scan_index;
  logic [CW-1:0]               kept_count;

  logic                        last_r;
  logic [skt_pkg::SQ_W-1:0]    sq_r;
  logic [DW-1:0]               offer_dist;
  logic [INDEX_BITS-1:0]       offer_idx;

  // scan engine
  logic [CW-1:0]               ptr;
  logic [CW-1:0]               scan_n;
  logic                        rd_pend;
  logic [AW-1:0]               rd_idx;
  logic                        have_best;
  logic [DW-1:0]               best_d;
  logic [INDEX_BITS-1:0]       best_i;
  logic [AW-1:0]               best_addr;
  logic [K_MAX-1:0]            used;
  logic [CW-1:0]               out_cnt;

  // combinational helpers
  logic                        accept;
  logic [skt_pkg::VAL_W-1:0]   diff;
  logic [skt_pkg::SQ_W-1:0]    sq;
  logic [DW:0]                 sum_wide;
  logic [DW-1:0]               sum_sat;
  logic [31:0]                 tk32;
  logic [CW-1:0]               k_eff;
  logic                        issue;
  logic                        scan_done;
  logic [EW-1:0]               rd_data;
  logic [DW-1:0]               rd_d;
  logic [INDEX_BITS-1:0]       rd_i;
  logic [DW-1:0]               cmp_a_d, cmp_b_d;
  logic [INDEX_BITS-1:0]       cmp_a_i, cmp_b_i;
  logic                        cmp_gt;
  logic                        take;
  logic                        ram_we;
  logic [AW-1:0]               ram_waddr;
  logic [EW-1:0]               ram_wdata;
  logic                        cfg_write;

  assign busy   = (state != ST_IDLE);
  assign accept = start && !busy;
  assign pready = 1'b1;
  assign prdata = {{(32 - skt_pkg::TOPK_W){1'b0}}, top_k};

  assign cfg_write = psel && penable && pwrite && pready
                     && (paddr[1:0] == skt_pkg::REG_TOP_K);

  // Absolute difference and its square, registered at accept
  assign diff = (query_value > base_value) ? (query_value - base_value)
                                           : (base_value - query_value);
  assign sq   = skt_pkg::SQ_W'(diff) * skt_pkg::SQ_W'(diff);

  // Saturating accumulate
  assign sum_wide = {1'b0, running_sum} + (DW + 1)'(sq_r);
  assign sum_sat  = sum_wide[DW] ? skt_pkg::SUM_MAX : sum_wide[DW-1:0];

  // Clamp top_k into 1..K_MAX
  assign tk32 = 32'(top_k);
  always_comb begin
    if (top_k == '0) begin
      k_eff = CW'(1);
    end else if (tk32 > 32'(K_MAX)) begin
      k_eff = CW'(K_MAX);
    end else begin
      k_eff = CW'(tk32);
    end
  end

  // Scan sequencing: one read issued per cycle, compared in the cycle after it is issued
  assign issue     = ((state == ST_MSCAN) || (state == ST_DSCAN)) && (ptr < scan_n);
  assign scan_done = ((state == ST_MSCAN) || (state == ST_DSCAN)) && (ptr == scan_n)
                     && !rd_pend;
  assign rd_d      = rd_data[EW-1:INDEX_BITS];
  assign rd_i      = rd_data[INDEX_BITS-1:0];

  // Shared (distance, index) comparator: cmp_gt = A greater than B
  always_comb begin
    if (state == ST_DSCAN) begin
      cmp_a_d = best_d;
      cmp_a_i = best_i;
      cmp_b_d = rd_d;
      cmp_b_i = rd_i;
    end else begin
      cmp_a_d = rd_d;
      cmp_a_i = rd_i;
      cmp_b_d = best_d;
      cmp_b_i = best_i;
    end
    if (cmp_a_d != cmp_b_d) begin
      cmp_gt = (cmp_a_d > cmp_b_d);
    end else begin
      cmp_gt = (cmp_a_i > cmp_b_i);
    end
  end

  // MSCAN keeps the larger, DSCAN the smaller unsent; the first of equal pairs wins
  always_comb begin
    if (state == ST_DSCAN) begin
      take = rd_pend && !used[rd_idx] && (!have_best || cmp_gt);
    end else begin
      take = rd_pend && (!have_best || cmp_gt);
    end
  end

  // Entry writes: append while filling, replace the maximum once full if the offer is smaller
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = best_addr;
    ram_wdata = {offer_dist, offer_idx};
    if ((state == ST_OFFER) && (kept_count < k_eff)) begin
      ram_we    = 1'b1;
      ram_waddr = kept_count[AW-1:0];
    end else if ((state == ST_MSCAN) && scan_done && (offer_dist < best_d)) begin
      ram_we    = 1'b1;
    end
  end

  skt_ram #(
    .WIDTH (EW),
    .DEPTH (K_MAX)
  ) u_entries (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ptr[AW-1:0]),
    .rdata (rd_data)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      top_k        <= skt_pkg::TOPK_RESET;
      running_sum  <= '0;
      scan_index   <= '0;
      kept_count   <= '0;
      rd_pend      <= 1'b0;
      have_best    <= 1'b0;
      used         <= '0;
      out_cnt      <= '0;
      result_valid <= 1'b0;
    end else begin
      // result strobe lasts one cycle
      result_valid <= 1'b0;

      if (cfg_write) begin
        top_k <= pwdata[skt_pkg::TOPK_W-1:0];
      end

      // scan pipeline: advance pointer, track the read in flight
      rd_pend <= issue;
      rd_idx  <= ptr[AW-1:0];
      if (issue) begin
        ptr <= ptr + CW'(1);
      end
      if (take) begin
        have_best <= 1'b1;
        best_d    <= rd_d;
        best_i    <= rd_i;
        best_addr <= rd_idx;
      end

      unique case (state)
        ST_IDLE: begin
          if (accept) begin
            last_r <= last_component;
            sq_r   <= sq;
            state  <= (mode == skt_pkg::MODE_DRAIN) ? ST_DRAIN : ST_ACC;
          end
        end

        ST_ACC: begin
          if (last_r) begin
            offer_dist  <= sum_sat;
            offer_idx   <= scan_index;
            scan_index  <= scan_index + INDEX_BITS'(1);
            running_sum <= '0;
            state       <= ST_OFFER;
          end else begin
            running_sum <= sum_sat;
            state       <= ST_IDLE;
          end
        end

        ST_OFFER: begin
          if (kept_count < k_eff) begin
            kept_count <= kept_count + CW'(1);
            state      <= ST_IDLE;
          end else begin
            ptr       <= '0;
            scan_n    <= kept_count;
            have_best <= 1'b0;
            state     <= ST_MSCAN;
          end
        end

        ST_MSCAN: begin
          if (scan_done) begin
            state <= ST_IDLE;
          end
        end

        ST_DRAIN: begin
          // clear the set and counters; entries are read below the snapshot
          running_sum <= '0;
          scan_index  <= '0;
          kept_count  <= '0;
          used        <= '0;
          out_cnt     <= '0;
          if (kept_count == '0) begin
            result_valid   <= 1'b1;
            neighbor_index <= '0;
            distance       <= '0;
            empty_res      <= 1'b1;
            last_result    <= 1'b1;
            state          <= ST_IDLE;
          end else begin
            ptr       <= '0;
            scan_n    <= kept_count;
            have_best <= 1'b0;
            state     <= ST_DSCAN;
          end
        end

        ST_DSCAN: begin
          if (scan_done) begin
            result_valid     <= 1'b1;
            neighbor_index   <= best_i;
            distance         <= best_d;
            empty_res        <= 1'b0;
            last_result      <= ((out_cnt + CW'(1)) == scan_n);
            used[best_addr]  <= 1'b1;
            out_cnt          <= out_cnt + CW'(1);
            ptr              <= '0;
            have_best        <= 1'b0;
            if ((out_cnt + CW'(1)) == scan_n) begin
              state <= ST_IDLE;
            end
          end
        end

        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

`ifndef ASSERT_OFF
  // Accepted command always raises busy in the next cycle
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    accept |=> busy)
    else $error("accepted transaction did not raise busy");

  // Set never grows beyond its storage
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    32'(kept_count) <= 32'(K_MAX))
    else $error("kept_count exceeds K_MAX");

  // Empty drain result is always the final one
  a_empty_last: assert property (@(posedge clk) disable iff (rst)
    (result_valid && empty_res) |-> last_result)
    else $error("empty result not marked last");

  // Results only come out of a drain, which leaves the set empty
  a_result_drained: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> (kept_count == '0))
    else $error("result while set not cleared");
`endif

endmodule
